/* hdl/m3i_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and the cofactor index table for the 3x3 matrix inverse.
// No dependencies.
package m3i_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QW        = 32;
    localparam int NUM_W     = 64 + 2 * FRAC_BITS;
    localparam int DET_W     = 98;
    localparam int DMAG_W    = 97;
    localparam int CMP_W     = DMAG_W + QW;
    localparam int DIV_STEPS = 32;
    localparam int FRONT     = 5;
    localparam int NST       = FRONT + 1 + DIV_STEPS + 1;
    localparam int DSH_R     = (3 * FRAC_BITS >= 32) ? 3 * FRAC_BITS - 32 : 0;
    localparam int DSH_L     = (3 * FRAC_BITS < 32) ? 32 - 3 * FRAC_BITS : 0;
    localparam int SH_W      = DMAG_W + 8;

    localparam int ADJ_IDX [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef logic signed [31:0] t_word;
    typedef logic signed [63:0] t_wide;
    typedef logic [63:0]        t_mag;
    typedef logic [DMAG_W-1:0]  t_dmag;

    typedef struct packed {
        logic        sing;
        logic        dovf;
        logic [63:0] det;
    } t_side;

endpackage

/* hdl/m3i_in_if.sv */
`timescale 1ns / 1ps
// Input channel carrying one 3x3 matrix word.
// Depends on m3i_pkg.
interface m3i_in_if import m3i_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word a_r0c0, a_r0c1, a_r0c2;
    t_word a_r1c0, a_r1c1, a_r1c2;
    t_word a_r2c0, a_r2c1, a_r2c2;

    modport source (output valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
                    a_r2c0, a_r2c1, a_r2c2, input ready);
    modport sink (input valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
                  a_r2c0, a_r2c1, a_r2c2, output ready);
endinterface

/* hdl/m3i_out_if.sv */
`timescale 1ns / 1ps
// Output channel carrying one inverse, determinant and flags word.
// Depends on m3i_pkg.
interface m3i_out_if import m3i_pkg::*; ();
    logic        valid;
    logic        ready;
    t_word       inv_r0c0, inv_r0c1, inv_r0c2;
    t_word       inv_r1c0, inv_r1c1, inv_r1c2;
    t_word       inv_r2c0, inv_r2c1, inv_r2c2;
    logic [63:0] determinant;
    logic        singular;
    logic        overflow;

    modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                    inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, determinant, singular,
                    overflow, input ready);
    modport sink (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                  inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, determinant, singular,
                  overflow, output ready);
endinterface

/* hdl/matrix3_inverse.sv */
`timescale 1ns / 1ps
// 3x3 matrix inverse by adjugate and determinant in signed fixed point.
// Depends on m3i_pkg, m3i_in_if, m3i_out_if and m3i_div_lane.
//
// The block takes one matrix word on i_in and returns one result word on o_out:
// nine saturated inverse entries, the Q32.32 determinant, and singular and
// overflow flags. Both channels move a word when valid and ready are high.
// Throughput is one word per cycle while the receiver is ready. Five front
// stages form the products, the adjugate, the partial products of the
// determinant, its sum and its magnitude; a setup stage and 32 restoring
// divider stages, one quotient bit each, produce all nine entries in parallel;
// a last register holds the output word. Every stage has its own valid bit
// and advances when the next stage is empty or moving, so bubbles close up and
// input is taken while a result waits. When the receiver stalls, the pipe
// fills and then ready drops; nothing is lost or repeated. Reset clears the
// valid bits only.
module matrix3_inverse import m3i_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    m3i_in_if.sink      i_in,
    m3i_out_if.source   o_out
);

    logic [NST-1:0] r_vld;
    logic [NST:0]   rdy;
    logic [NST-1:0] en;

    always_comb begin
        rdy[NST] = o_out.ready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        en = rdy[NST-1:0];
    end

    assign i_in.ready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    t_word a [9];
    assign a[0] = i_in.a_r0c0;
    assign a[1] = i_in.a_r0c1;
    assign a[2] = i_in.a_r0c2;
    assign a[3] = i_in.a_r1c0;
    assign a[4] = i_in.a_r1c1;
    assign a[5] = i_in.a_r1c2;
    assign a[6] = i_in.a_r2c0;
    assign a[7] = i_in.a_r2c1;
    assign a[8] = i_in.a_r2c2;

    t_wide r1_pa [9];
    t_wide r1_pb [9];
    t_word r1_a  [3];
    t_wide r2_adj [9];
    t_word r2_a   [3];
    t_wide r3_adj [9];
    logic signed [64:0] r3_pl [3];
    t_wide              r3_ph [3];
    t_wide r4_adj [9];
    logic signed [DET_W-1:0] r4_det;
    t_mag  r5_mag [9];
    logic  r5_neg [9];
    t_dmag r5_dmag;
    t_side r5_side;

    for (genvar i = 0; i < 9; i++) begin : g_adj
        always_ff @(posedge i_clk) begin
            if (en[0]) begin
                r1_pa[i] <= a[ADJ_IDX[i][0]] * a[ADJ_IDX[i][1]];
                r1_pb[i] <= a[ADJ_IDX[i][2]] * a[ADJ_IDX[i][3]];
            end
            if (en[1]) r2_adj[i] <= r1_pa[i] - r1_pb[i];
            if (en[2]) r3_adj[i] <= r2_adj[i];
            if (en[3]) r4_adj[i] <= r3_adj[i];
            if (en[4]) begin
                r5_mag[i] <= r4_adj[i][63] ? t_mag'(-r4_adj[i]) : t_mag'(r4_adj[i]);
                r5_neg[i] <= r4_adj[i][63] ^ r4_det[DET_W-1];
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_row
        always_ff @(posedge i_clk) begin
            if (en[0]) r1_a[j] <= a[j];
            if (en[1]) r2_a[j] <= r1_a[j];
            if (en[2]) begin
                r3_pl[j] <= r2_a[j] * $signed({1'b0, r2_adj[3*j][31:0]});
                r3_ph[j] <= r2_a[j] * $signed(r2_adj[3*j][63:32]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_det <= (DET_W'(r3_ph[0]) <<< 32) + DET_W'(r3_pl[0])
                    + (DET_W'(r3_ph[1]) <<< 32) + DET_W'(r3_pl[1])
                    + (DET_W'(r3_ph[2]) <<< 32) + DET_W'(r3_pl[2]);
        end
    end

    logic                    n_dneg;
    logic signed [DET_W-1:0] n_dabs;
    t_dmag                   n_dmag;
    logic [SH_W-1:0]         n_sh;
    logic [63:0]             n_dlim;
    logic                    n_dovf;
    logic [63:0]             n_dm;

    always_comb begin
        n_dneg = r4_det[DET_W-1];
        n_dabs = n_dneg ? -r4_det : r4_det;
        n_dmag = n_dabs[DMAG_W-1:0];
        n_sh   = (SH_W'(n_dmag) << DSH_L) >> DSH_R;
        n_dlim = n_dneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        n_dovf = n_sh > SH_W'(n_dlim);
        n_dm   = n_dovf ? n_dlim : n_sh[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_dmag       <= n_dmag;
            r5_side.sing  <= (r4_det == '0);
            r5_side.dovf  <= n_dovf;
            r5_side.det   <= n_dneg ? -n_dm : n_dm;
        end
    end

    t_dmag r_dmp [DIV_STEPS];
    t_side r_sd  [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (en[FRONT]) begin
            r_sd[0]  <= r5_side;
            r_dmp[0] <= r5_dmag;
        end
        for (int j = 1; j <= DIV_STEPS; j++) begin
            if (en[FRONT+j]) begin
                r_sd[j] <= r_sd[j-1];
            end
        end
        for (int j = 1; j < DIV_STEPS; j++) begin
            if (en[FRONT+j]) begin
                r_dmp[j] <= r_dmp[j-1];
            end
        end
    end

    t_word lane_val [9];
    logic  lane_sat [9];

    for (genvar i = 0; i < 9; i++) begin : g_lane
        m3i_div_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en[FRONT+DIV_STEPS:FRONT]),
            .i_mag  (r5_mag[i]),
            .i_neg  (r5_neg[i]),
            .i_dmag (r5_dmag),
            .i_dmp  (r_dmp),
            .o_val  (lane_val[i]),
            .o_sat  (lane_sat[i])
        );
    end

    t_word       r_inv [9];
    logic [63:0] r_det;
    logic        r_sing;
    logic        r_ovf;
    logic        n_any_sat;

    always_comb begin
        n_any_sat = r_sd[DIV_STEPS].dovf;
        for (int i = 0; i < 9; i++) begin
            n_any_sat = n_any_sat | lane_sat[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) begin
            for (int i = 0; i < 9; i++) begin
                r_inv[i] <= r_sd[DIV_STEPS].sing ? '0 : lane_val[i];
            end
            r_det  <= r_sd[DIV_STEPS].sing ? '0 : r_sd[DIV_STEPS].det;
            r_sing <= r_sd[DIV_STEPS].sing;
            r_ovf  <= !r_sd[DIV_STEPS].sing && n_any_sat;
        end
    end

    assign o_out.valid       = r_vld[NST-1];
    assign o_out.inv_r0c0    = r_inv[0];
    assign o_out.inv_r0c1    = r_inv[1];
    assign o_out.inv_r0c2    = r_inv[2];
    assign o_out.inv_r1c0    = r_inv[3];
    assign o_out.inv_r1c1    = r_inv[4];
    assign o_out.inv_r1c2    = r_inv[5];
    assign o_out.inv_r2c0    = r_inv[6];
    assign o_out.inv_r2c1    = r_inv[7];
    assign o_out.inv_r2c2    = r_inv[8];
    assign o_out.determinant = r_det;
    assign o_out.singular    = r_sing;
    assign o_out.overflow    = r_ovf;

endmodule

/* hdl/m3i_div_lane.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider for one inverse entry, one quotient bit per stage,
// with saturation of the signed result. Depends on m3i_pkg.
module m3i_div_lane import m3i_pkg::*; (
    input  logic                 i_clk,
    input  logic [DIV_STEPS:0]   i_en,
    input  t_mag                 i_mag,
    input  logic                 i_neg,
    input  t_dmag                i_dmag,
    input  t_dmag                i_dmp [DIV_STEPS],
    output t_word                o_val,
    output logic                 o_sat
);

    logic [NUM_W-1:0] r_rem [DIV_STEPS+1];
    logic [QW-1:0]    r_q   [DIV_STEPS+1];
    logic             r_ovf [DIV_STEPS+1];
    logic             r_neg [DIV_STEPS+1];
    logic [NUM_W-1:0] n_num;

    assign n_num = NUM_W'(i_mag) << (2 * FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= n_num;
            r_q[0]   <= '0;
            r_ovf[0] <= CMP_W'(n_num) >= (CMP_W'(i_dmag) << QW);
            r_neg[0] <= i_neg;
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
        logic [CMP_W-1:0] n_trial;
        logic             n_ge;
        assign n_trial = CMP_W'(i_dmp[j-1]) << (DIV_STEPS - j);
        assign n_ge    = CMP_W'(r_rem[j-1]) >= n_trial;
        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j] <= n_ge ? r_rem[j-1] - n_trial[NUM_W-1:0] : r_rem[j-1];
                r_q[j]   <= r_q[j-1] | (QW'(n_ge) << (DIV_STEPS - j));
                r_ovf[j] <= r_ovf[j-1];
                r_neg[j] <= r_neg[j-1];
            end
        end
    end

    logic [QW:0] n_lim;
    logic [QW:0] n_m;

    always_comb begin
        n_lim = r_neg[DIV_STEPS] ? (33'd1 << (QW - 1)) : ((33'd1 << (QW - 1)) - 33'd1);
        o_sat = r_ovf[DIV_STEPS] || ({1'b0, r_q[DIV_STEPS]} > n_lim);
        n_m   = o_sat ? n_lim : {1'b0, r_q[DIV_STEPS]};
        o_val = r_neg[DIV_STEPS] ? t_word'(-n_m[QW-1:0]) : t_word'(n_m[QW-1:0]);
    end

endmodule
